// ===== rtl/cvse_pkg.sv =====
`default_nettype none
package cvse_pkg;

	// width of the internal cell counter
	localparam int CELL_INDEX_BITS = 24;

	localparam int TARGET_W   = 24;
	localparam int BYTE_W     = 8;
	localparam int WORD_ID_W  = 22;
	localparam int POS_W      = 8;
	localparam int PARTIAL_W  = 14;
	localparam int PAYLOAD6_W = 6;

	// variable-byte prefix masks
	localparam logic [BYTE_W-1:0] MARK_MULTI  = 8'h80;
	localparam logic [BYTE_W-1:0] MARK_PREFIX = 8'hC0;
	localparam logic [BYTE_W-1:0] MASK_LOW6   = 8'h3F;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              frame_start;
	} in_t;

	typedef struct packed {
		logic [WORD_ID_W-1:0] word_id;
		logic [POS_W-1:0]     word_position;
		logic                 last_word;
		logic                 cell_empty;
	} out_t;

endpackage
`default_nettype wire

// ===== rtl/cvse_if.sv =====
`default_nettype none
interface cvse_in_if;
	logic          valid;
	logic          ready;
	cvse_pkg::in_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface cvse_out_if;
	logic           valid;
	logic           ready;
	cvse_pkg::out_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/cell_vbyte_stream_extractor.sv =====
// Cell variable-byte stream extractor. Feed the cell area one byte per transfer on
// "stream", with frame_start high on its first byte. Each cell is a count byte and
// then that many word ids (0xxxxxxx: 7 bits; 10xxxxxx + 1 byte: 14 bits;
// 11xxxxxx + 2 bytes: 22 bits). Cells before target_cell are skipped; each id of
// the target cell comes out on "result" with its position and last_word on the
// final one, and an empty target cell gives a single transfer with cell_empty and
// last_word set. Everything after it is dropped until the next frame_start. The
// block takes one byte every clock cycle: a byte passes an input register and then
// the parse logic into the result register, which drives "result". Only
// back-pressure on "result" slows the stream: while a result waits to be taken,
// the input register still takes one byte and then holds it.
// Write target_cell through cfg_we/cfg_data only while the block is idle.
`default_nettype none
module cell_vbyte_stream_extractor (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [cvse_pkg::TARGET_W-1:0]       cfg_data,
	cvse_in_if.sink                            stream,
	cvse_out_if.source                         result
);

	// parse phase codes
	localparam logic [2:0] PH_COUNT = 3'd0; // count byte of a cell
	localparam logic [2:0] PH_FIRST = 3'd1; // first byte of a word
	localparam logic [2:0] PH_TWO_B = 3'd2; // second byte of a two-byte word
	localparam logic [2:0] PH_THR_B = 3'd3; // second byte of a three-byte word
	localparam logic [2:0] PH_THR_C = 3'd4; // third byte of a three-byte word

	localparam int CNT_W = cvse_pkg::CELL_INDEX_BITS;

	// configuration
	logic [cvse_pkg::TARGET_W-1:0] target_q;

	// input register
	logic          valid_s1;
	cvse_pkg::in_t item_s1;

	// parser state
	logic [2:0]                       phase_q;
	logic [CNT_W-1:0]                 cell_cnt_q;
	logic [cvse_pkg::POS_W-1:0]       words_left_q;
	logic [cvse_pkg::POS_W-1:0]       pos_q;
	logic [cvse_pkg::PARTIAL_W-1:0]   partial_q;
	logic                             finished_q;
	logic                             in_target_q;

	// result register
	logic           out_valid_q;
	cvse_pkg::out_t out_q;

	// next-state values
	logic [2:0]                       phase_d;
	logic [CNT_W-1:0]                 cell_cnt_d;
	logic [cvse_pkg::POS_W-1:0]       words_left_d;
	logic [cvse_pkg::POS_W-1:0]       pos_d;
	logic [cvse_pkg::PARTIAL_W-1:0]   partial_d;
	logic                             finished_d;
	logic                             in_target_d;
	logic                             emit;
	cvse_pkg::out_t                   out_d;

	// per-byte scratch
	logic [2:0]                       ph_e;
	logic [CNT_W-1:0]                 cnt_e;
	logic [cvse_pkg::POS_W-1:0]       wl_e;
	logic [cvse_pkg::POS_W-1:0]       pos_e;
	logic [cvse_pkg::PARTIAL_W-1:0]   part_e;
	logic                             fin_e;
	logic                             tgt_e;
	logic [cvse_pkg::BYTE_W-1:0]      b;
	logic                             word_end;
	logic [cvse_pkg::WORD_ID_W-1:0]   word_val;
	logic [cvse_pkg::POS_W-1:0]       wl_dec;

	logic res_free;
	logic proc;

	// result slot free this cycle: empty, or its transfer happens now
	assign res_free     = !out_valid_q || result.ready;
	assign proc         = valid_s1 && res_free;
	assign stream.ready = !valid_s1 || res_free;

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_we) begin
			target_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			item_s1 <= stream.payload;
		end
	end

	// parse one byte
	always_comb begin
		b = item_s1.data_byte;

		// frame start restarts everything, this byte then being the count of cell 0
		if (item_s1.frame_start) begin
			ph_e   = PH_COUNT;
			cnt_e  = '0;
			wl_e   = '0;
			pos_e  = '0;
			part_e = '0;
			fin_e  = 1'b0;
			tgt_e  = 1'b0;
		end else begin
			ph_e   = phase_q;
			cnt_e  = cell_cnt_q;
			wl_e   = words_left_q;
			pos_e  = pos_q;
			part_e = partial_q;
			fin_e  = finished_q;
			tgt_e  = in_target_q;
		end

		phase_d      = ph_e;
		cell_cnt_d   = cnt_e;
		words_left_d = wl_e;
		pos_d        = pos_e;
		partial_d    = part_e;
		finished_d   = fin_e;
		in_target_d  = tgt_e;
		emit         = 1'b0;
		out_d        = '0;
		word_end     = 1'b0;
		word_val     = '0;
		wl_dec       = wl_e - 1'b1;

		if (!fin_e) begin
			unique case (ph_e)
				PH_COUNT: begin
					in_target_d = (32'(cnt_e) == 32'(target_q));
					pos_d       = '0;
					if (b == '0) begin
						if (in_target_d) begin
							emit             = 1'b1;
							out_d.last_word  = 1'b1;
							out_d.cell_empty = 1'b1;
							finished_d       = 1'b1;
						end else begin
							cell_cnt_d = cnt_e + 1'b1;
						end
					end else begin
						words_left_d = b;
						phase_d      = PH_FIRST;
					end
				end
				PH_FIRST: begin
					if ((b & cvse_pkg::MARK_MULTI) == '0) begin
						word_end = 1'b1;
						word_val = cvse_pkg::WORD_ID_W'(b);
					end else begin
						partial_d = cvse_pkg::PARTIAL_W'(b & cvse_pkg::MASK_LOW6);
						phase_d   = ((b & cvse_pkg::MARK_PREFIX) == cvse_pkg::MARK_MULTI)
							? PH_TWO_B : PH_THR_B;
					end
				end
				PH_TWO_B: begin
					word_end = 1'b1;
					word_val = cvse_pkg::WORD_ID_W'({part_e[cvse_pkg::PAYLOAD6_W-1:0], b});
				end
				PH_THR_B: begin
					partial_d = {part_e[cvse_pkg::PAYLOAD6_W-1:0], b};
					phase_d   = PH_THR_C;
				end
				PH_THR_C: begin
					word_end = 1'b1;
					word_val = {part_e, b};
				end
				default: begin
					phase_d = PH_COUNT;
				end
			endcase

			// a word has completed
			if (word_end) begin
				words_left_d = wl_dec;
				if (tgt_e) begin
					emit                = 1'b1;
					out_d.word_id       = word_val;
					out_d.word_position = pos_e;
					out_d.last_word     = (wl_dec == '0);
					pos_d               = pos_e + 1'b1;
				end
				if (wl_dec == '0) begin
					if (tgt_e) begin
						finished_d = 1'b1;
					end else begin
						cell_cnt_d = cnt_e + 1'b1;
					end
					phase_d = PH_COUNT;
				end else begin
					phase_d = PH_FIRST;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_COUNT;
			cell_cnt_q   <= '0;
			words_left_q <= '0;
			pos_q        <= '0;
			partial_q    <= '0;
			finished_q   <= 1'b0;
			in_target_q  <= 1'b0;
		end else if (proc) begin
			phase_q      <= phase_d;
			cell_cnt_q   <= cell_cnt_d;
			words_left_q <= words_left_d;
			pos_q        <= pos_d;
			partial_q    <= partial_d;
			finished_q   <= finished_d;
			in_target_q  <= in_target_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= emit;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			out_q <= out_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cvse_checker.sv =====
`default_nettype none
module cvse_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 res_valid,
	input wire                                 res_ready,
	input wire [cvse_pkg::WORD_ID_W-1:0]       res_word_id,
	input wire [cvse_pkg::POS_W-1:0]           res_word_position,
	input wire                                 res_last_word,
	input wire                                 res_cell_empty
);

	// an empty cell is a single closing transfer with zero id and position
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_cell_empty) |->
		(res_last_word && (res_word_id == '0) && (res_word_position == '0)))
		else $error("empty-cell result malformed");

	// nothing offered in the cycle after reset was seen
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !res_valid)
		else $error("result valid straight after reset");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid)
		else $error("result valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=>
		($stable(res_word_id) && $stable(res_word_position) &&
		 $stable(res_last_word) && $stable(res_cell_empty)))
		else $error("result payload changed while stalled");

endmodule

bind cell_vbyte_stream_extractor cvse_checker u_cvse_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (result.valid),
	.res_ready         (result.ready),
	.res_word_id       (result.payload.word_id),
	.res_word_position (result.payload.word_position),
	.res_last_word     (result.payload.last_word),
	.res_cell_empty    (result.payload.cell_empty)
);
`default_nettype wire
